// ===== rtl/sts_pkg.sv =====
// Package for the step task sequencer: item and result structs,
// status and notification types, mode and result-code constants.
// No dependencies.
`timescale 1ns / 1ps

package sts_pkg;

  // Item modes
  localparam logic [2:0] MODE_SCAN     = 3'd0;
  localparam logic [2:0] MODE_ASYNC    = 3'd1;
  localparam logic [2:0] MODE_START    = 3'd2;
  localparam logic [2:0] MODE_SET_NEXT = 3'd3;
  localparam logic [2:0] MODE_INIT     = 3'd4;

  // Step result codes carried by a scan item
  localparam logic [2:0] RES_CURRENT    = 3'd0;
  localparam logic [2:0] RES_NEXT       = 3'd1;
  localparam logic [2:0] RES_STOP       = 3'd2;
  localparam logic [2:0] RES_ASYNC_WAIT = 3'd3;
  localparam logic [2:0] RES_FINISH     = 3'd4;
  localparam logic [2:0] RES_RESTART    = 3'd5;

  localparam logic [7:0] STEP_COUNT_RESET = 8'd1;

  typedef enum logic [1:0] {
    ST_STOPPED  = 2'd0,
    ST_RUNNING  = 2'd1,
    ST_ASYNC    = 2'd2,
    ST_FINISHED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    NT_NONE    = 3'd0,
    NT_STOP    = 3'd1,
    NT_FINISH  = 3'd2,
    NT_RESTART = 3'd3,
    NT_ASYNC   = 3'd4
  } notify_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] step_result;
    logic [7:0] new_next_step;
  } item_t;

  typedef struct packed {
    logic [7:0] current_step;
    status_t    task_status;
    notify_t    notify;
    logic       result_used;
  } result_t;

endpackage

// ===== rtl/sts_in_reg.sv =====
// Input register of the step task sequencer: captures one item and
// holds it until the core takes it. Depends on sts_pkg.
`timescale 1ns / 1ps

module sts_in_reg
  import sts_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  take,
  output logic  full,
  output item_t item
);

  logic accept;
  logic full_next;

  // Stall only while a held item cannot move on this cycle
  assign in_stall  = full && !take;
  assign accept    = in_valid && !in_stall;
  assign full_next = accept || (full && !take);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
  end

endmodule

// ===== rtl/sts_core.sv =====
// Sequencer state and per-item decode: step index, pending step,
// run status and the step count register. Depends on sts_pkg.
`timescale 1ns / 1ps

module sts_core
  import sts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       fire,
  input  item_t      item,
  output result_t    res
);

  logic [7:0] step_count;
  logic [7:0] step_index;
  logic [7:0] pending_step;
  status_t    run_status;

  logic [7:0] step_index_next;
  logic [7:0] pending_step_next;
  status_t    run_status_next;
  notify_t    ntf;
  logic       used;

  always_comb begin
    step_index_next   = step_index;
    pending_step_next = pending_step;
    run_status_next   = run_status;
    ntf               = NT_NONE;
    used              = 1'b0;
    case (item.mode)
      MODE_SCAN: begin
        if (run_status == ST_FINISHED || run_status == ST_STOPPED) begin
          // nothing to do while idle
        end else if (step_index >= step_count) begin
          run_status_next = ST_FINISHED;
          ntf             = NT_FINISH;
        end else begin
          used = 1'b1;
          case (item.step_result)
            RES_CURRENT: begin
              run_status_next = ST_RUNNING;
            end
            RES_NEXT: begin
              step_index_next   = pending_step;
              pending_step_next = pending_step + 8'd1;
              run_status_next   = ST_RUNNING;
            end
            RES_STOP: begin
              run_status_next = ST_STOPPED;
              ntf             = NT_STOP;
            end
            RES_ASYNC_WAIT: begin
              if (run_status == ST_ASYNC) begin
                step_index_next   = pending_step;
                pending_step_next = pending_step + 8'd1;
                run_status_next   = ST_RUNNING;
              end else begin
                run_status_next = ST_STOPPED;
              end
            end
            RES_RESTART: begin
              step_index_next = 8'd0;
              run_status_next = ST_RUNNING;
              ntf             = NT_RESTART;
            end
            default: begin
              // explicit finish and the unused codes
              run_status_next = ST_FINISHED;
              ntf             = NT_FINISH;
            end
          endcase
        end
      end
      MODE_ASYNC: begin
        if (run_status == ST_STOPPED) begin
          step_index_next   = pending_step;
          pending_step_next = pending_step + 8'd1;
          run_status_next   = ST_RUNNING;
        end else begin
          run_status_next = ST_ASYNC;
        end
        ntf = NT_ASYNC;
      end
      MODE_START: begin
        step_index_next = 8'd0;
        run_status_next = ST_RUNNING;
      end
      MODE_SET_NEXT: begin
        pending_step_next = item.new_next_step;
      end
      MODE_INIT: begin
        // reject init on an empty step list
        if (step_count != 8'd0) begin
          step_index_next = 8'd0;
          run_status_next = ST_STOPPED;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.current_step = step_index_next;
    res.task_status  = run_status_next;
    res.notify       = ntf;
    res.result_used  = used;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count   <= STEP_COUNT_RESET;
      step_index   <= 8'd0;
      pending_step <= 8'd0;
      run_status   <= ST_STOPPED;
    end else begin
      if (cfg_write) begin
        step_count <= cfg_data;
      end
      if (fire) begin
        step_index   <= step_index_next;
        pending_step <= pending_step_next;
        run_status   <= run_status_next;
      end
    end
  end

`ifndef ASSERT_OFF
  a_async_notify: assert property (@(posedge clk) disable iff (rst)
    fire |-> ((res.notify == NT_ASYNC) == (item.mode == MODE_ASYNC)))
    else $error("async notification does not match item mode");

  a_used_when_active: assert property (@(posedge clk) disable iff (rst)
    (fire && res.result_used) |-> (run_status == ST_RUNNING || run_status == ST_ASYNC))
    else $error("step result consumed while not active");

  a_finish_status: assert property (@(posedge clk) disable iff (rst)
    (fire && res.notify == NT_FINISH) |-> (res.task_status == ST_FINISHED))
    else $error("finish notification without finished status");

  a_set_next: assert property (@(posedge clk) disable iff (rst)
    (fire && item.mode == MODE_SET_NEXT) |=> (pending_step == $past(item.new_next_step)))
    else $error("pending step not loaded");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    (!fire && !$past(rst)) |=> ($stable(step_index) && $stable(run_status)))
    else $error("state changed without an item");
`endif

endmodule

// ===== rtl/sts_out_reg.sv =====
// Result register of the step task sequencer: holds one result until
// the receiver takes it. Depends on sts_pkg.
`timescale 1ns / 1ps

module sts_out_reg
  import sts_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  output logic    ready,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t res
);

  logic out_valid_next;

  // Free when empty or when the held result leaves this cycle
  assign ready          = !out_valid || !out_stall;
  assign out_valid_next = load || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

// ===== rtl/step_task_sequencer_core.sv =====
// An accepted item passes the input register, then the result register, before out_valid rises.
// One item per cycle while out_stall is low; each item makes exactly one result.
// The state registers load together with the result register, so the state update does not limit the rate.
// Reset (rst, synchronous): step index 0, pending step 0, status stopped,
// step count 1, both registers empty.
`timescale 1ns / 1ps

module step_task_sequencer_core
  import sts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] mode,
  input  logic [2:0] step_result,
  input  logic [7:0] new_next_step,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] current_step,
  output logic [1:0] task_status,
  output logic [2:0] notify,
  output logic       result_used
);

  item_t   in_item;
  item_t   item;
  result_t core_res;
  result_t res;
  logic    full;
  logic    out_ready;
  logic    fire;

  assign cfg_ready = 1'b1;

  assign in_item.mode          = mode;
  assign in_item.step_result   = step_result;
  assign in_item.new_next_step = new_next_step;

  // Advance the held item into the result register
  assign fire = full && out_ready;

  sts_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (out_ready),
    .full     (full),
    .item     (item)
  );

  sts_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (item),
    .res       (core_res)
  );

  sts_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res_in    (core_res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign current_step = res.current_step;
  assign task_status  = res.task_status;
  assign notify       = res.notify;
  assign result_used  = res.result_used;

endmodule
